>>> sv/styled_line_pixel_generator_assert.svh
// assertion macros for the styled line pixel generator
`ifndef STYLED_LINE_PIXEL_GENERATOR_ASSERT_SVH
`define STYLED_LINE_PIXEL_GENERATOR_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, checked on every rising edge out of reset
`define SLPG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("line pixel generator check failed");

// next-cycle implication
`define SLPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("line pixel generator check failed");

`else

`define SLPG_ASSERT_NOW(label, ante, cons)
`define SLPG_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> sv/slpg_pkg.sv
// shared types and constants for the styled line pixel generator
package slpg_pkg;

    localparam int COORD_BITS  = 12;
    localparam int PATTERN_LEN = 16;
    localparam int PAT_IDX_W   = $clog2(PATTERN_LEN);
    localparam int COLOR_W     = 4;
    localparam int DIM_W       = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DASH_PATTERN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEN_COLOR     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd3;

    // request operations
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // register reset values
    localparam logic [PATTERN_LEN-1:0] DASH_RESET   = 16'hFFFF;
    localparam logic [COLOR_W-1:0]     COLOR_RESET  = 4'd15;
    localparam logic [DIM_W-1:0]       WIDTH_RESET  = 11'd640;
    localparam logic [DIM_W-1:0]       HEIGHT_RESET = 11'd480;

    typedef struct packed {
        logic                         operation;
        logic signed [COORD_BITS-1:0] x_start;
        logic signed [COORD_BITS-1:0] y_start;
        logic signed [COORD_BITS-1:0] x_end;
        logic signed [COORD_BITS-1:0] y_end;
    } t_line_req;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic                         draw;
        logic [COLOR_W-1:0]           color;
        logic                         last;
    } t_pixel;

endpackage

>>> sv/styled_line_pixel_generator.sv
// styled line pixel generator: bresenham walker with dash pattern and screen clipping
// A start request loads both endpoints, rewinds the dash pattern and produces no
// pixel; every step request on an active line produces one pixel and advances the
// walk by one bresenham iteration, and the pixel at the second endpoint carries
// last and ends the line. Steps while no line is active are swallowed. The draw
// flag is set when the dash pattern bit for the pixel's position in the line is
// one and the pixel lies in 0 <= x < screen_width, 0 <= y < screen_height; the
// pen colour rides along on every pixel. Throughput is one request per clock:
// the line state registers feed a short add/compare path straight into the
// output register, and a new request is taken whenever that register is empty
// or is being drained in the same cycle, so the pixel of a step is presented in
// the cycle after the step is taken. Configuration writes are always accepted
// and should only be issued while the block is idle.
`include "styled_line_pixel_generator_assert.svh"

module styled_line_pixel_generator
    import slpg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // line requests
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  t_line_req             i_req,
    // pixel results
    output logic                  o_pix_valid,
    input  logic                  i_pix_ready,
    output t_pixel                o_pix,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ERR_W = COORD_BITS + 2;      // running error term
    localparam int E2_W  = COORD_BITS + 3;      // doubled error and its update
    localparam int CMP_W = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;
    localparam logic [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1);
    localparam logic [PAT_IDX_W-1:0]  IDX_ONE   = PAT_IDX_W'(1);

    // configuration registers
    logic [PATTERN_LEN-1:0] r_dash;
    logic [COLOR_W-1:0]     r_color;
    logic [DIM_W-1:0]       r_width;
    logic [DIM_W-1:0]       r_height;

    // line walker state
    logic                         r_active;
    logic signed [COORD_BITS-1:0] r_walk_x;
    logic signed [COORD_BITS-1:0] r_walk_y;
    logic signed [COORD_BITS-1:0] r_target_x;
    logic signed [COORD_BITS-1:0] r_target_y;
    logic [COORD_BITS-1:0]        r_delta_x;
    logic [COORD_BITS-1:0]        r_delta_y;
    logic                         r_dir_x_neg;
    logic                         r_dir_y_neg;
    logic signed [ERR_W-1:0]      r_err;
    logic [PAT_IDX_W-1:0]         r_pat_idx;

    // output register
    logic   r_out_valid;
    t_pixel r_out;

    logic                         n_active;
    logic signed [COORD_BITS-1:0] n_walk_x;
    logic signed [COORD_BITS-1:0] n_walk_y;
    logic signed [ERR_W-1:0]      n_err;
    logic [PAT_IDX_W-1:0]         n_pat_idx;
    logic                         n_out_valid;
    t_pixel                       n_out;

    logic req_fire;
    logic is_start;
    logic is_emit;

    // start-side arithmetic
    logic                         st_x_less;
    logic                         st_y_less;
    logic signed [COORD_BITS:0]   st_dx_full;
    logic signed [COORD_BITS:0]   st_dy_full;
    logic [COORD_BITS-1:0]        st_dx;
    logic [COORD_BITS-1:0]        st_dy;
    logic signed [ERR_W-1:0]      st_err;

    // step-side arithmetic
    logic signed [E2_W-1:0] e2;
    logic signed [E2_W-1:0] dx_ext;
    logic signed [E2_W-1:0] dy_ext;
    logic signed [E2_W-1:0] err_upd;
    logic                   move_x;
    logic                   move_y;
    logic                   fin;
    logic                   on_screen;
    logic                   pat_bit;

    assign req_fire    = i_req_valid && o_req_ready;
    assign is_start    = req_fire && (i_req.operation == OP_START);
    assign is_emit     = req_fire && (i_req.operation == OP_STEP) && r_active;
    assign o_req_ready = !r_out_valid || i_pix_ready;
    assign o_cfg_ready = 1'b1;
    assign o_pix_valid = r_out_valid;
    assign o_pix       = r_out;

    // endpoint setup: absolute deltas, directions, initial error dx - dy
    always_comb begin
        st_x_less  = i_req.x_start < i_req.x_end;
        st_y_less  = i_req.y_start < i_req.y_end;
        st_dx_full = st_x_less
                   ? (COORD_BITS+1)'(i_req.x_end) - (COORD_BITS+1)'(i_req.x_start)
                   : (COORD_BITS+1)'(i_req.x_start) - (COORD_BITS+1)'(i_req.x_end);
        st_dy_full = st_y_less
                   ? (COORD_BITS+1)'(i_req.y_end) - (COORD_BITS+1)'(i_req.y_start)
                   : (COORD_BITS+1)'(i_req.y_start) - (COORD_BITS+1)'(i_req.y_end);
        st_dx      = st_dx_full[COORD_BITS-1:0];
        st_dy      = st_dy_full[COORD_BITS-1:0];
        st_err     = $signed({2'b00, st_dx}) - $signed({2'b00, st_dy});
    end

    // one bresenham iteration plus the per-pixel flags
    always_comb begin
        e2      = $signed({r_err, 1'b0});
        dx_ext  = $signed({3'b000, r_delta_x});
        dy_ext  = $signed({3'b000, r_delta_y});
        move_x  = e2 > -dy_ext;
        move_y  = e2 < dx_ext;
        err_upd = E2_W'(r_err) - (move_x ? dy_ext : '0) + (move_y ? dx_ext : '0);

        fin     = (r_walk_x == r_target_x) && (r_walk_y == r_target_y);
        pat_bit = r_dash[r_pat_idx];
        // negative coordinates are off screen, otherwise compare against the bounds
        on_screen = !r_walk_x[COORD_BITS-1] && !r_walk_y[COORD_BITS-1]
                 && (CMP_W'($unsigned(r_walk_x)) < CMP_W'(r_width))
                 && (CMP_W'($unsigned(r_walk_y)) < CMP_W'(r_height));
    end

    // next state of the walker
    always_comb begin
        n_active  = r_active;
        n_walk_x  = r_walk_x;
        n_walk_y  = r_walk_y;
        n_err     = r_err;
        n_pat_idx = r_pat_idx;
        if (is_start) begin
            n_active  = 1'b1;
            n_walk_x  = i_req.x_start;
            n_walk_y  = i_req.y_start;
            n_err     = st_err;
            n_pat_idx = '0;
        end else if (is_emit) begin
            if (fin) begin
                n_active = 1'b0;
            end else begin
                n_err     = err_upd[ERR_W-1:0];
                n_pat_idx = r_pat_idx + IDX_ONE;
                if (move_x) begin
                    n_walk_x = r_dir_x_neg ? r_walk_x - COORD_ONE : r_walk_x + COORD_ONE;
                end
                if (move_y) begin
                    n_walk_y = r_dir_y_neg ? r_walk_y - COORD_ONE : r_walk_y + COORD_ONE;
                end
            end
        end
    end

    // output register: load on an emitting step, drain on acceptance downstream
    always_comb begin
        n_out_valid   = r_out_valid && !i_pix_ready;
        n_out         = r_out;
        if (is_emit) begin
            n_out_valid   = 1'b1;
            n_out.pixel_x = r_walk_x;
            n_out.pixel_y = r_walk_y;
            n_out.draw    = pat_bit && on_screen;
            n_out.color   = r_color;
            n_out.last    = fin;
        end
    end

    // control and configuration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_dash      <= DASH_RESET;
            r_color     <= COLOR_RESET;
            r_width     <= WIDTH_RESET;
            r_height    <= HEIGHT_RESET;
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_DASH_PATTERN:  r_dash   <= i_cfg_data[PATTERN_LEN-1:0];
                    CFG_PEN_COLOR:     r_color  <= i_cfg_data[COLOR_W-1:0];
                    CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                    CFG_SCREEN_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                    default:           r_dash   <= r_dash;
                endcase
            end
        end
    end

    // datapath registers, only meaningful while a line is active or a pixel waits
    always_ff @(posedge i_clk) begin
        r_walk_x  <= n_walk_x;
        r_walk_y  <= n_walk_y;
        r_err     <= n_err;
        r_pat_idx <= n_pat_idx;
        r_out     <= n_out;
        if (is_start) begin
            r_target_x  <= i_req.x_end;
            r_target_y  <= i_req.y_end;
            r_delta_x   <= st_dx;
            r_delta_y   <= st_dy;
            r_dir_x_neg <= !st_x_less;
            r_dir_y_neg <= !st_y_less;
        end
    end

    // a start always leaves an active line with the pattern rewound
    `SLPG_ASSERT_NEXT(a_start_arms, is_start, r_active && (r_pat_idx == '0))
    // the final pixel of a line closes it
    `SLPG_ASSERT_NEXT(a_last_ends_line, is_emit && fin, !r_active && o_pix_valid && o_pix.last)
    // every step on an active line shows up as a pixel next cycle
    `SLPG_ASSERT_NEXT(a_step_emits, is_emit, o_pix_valid)
    // a request never lands on top of a stalled pixel
    `SLPG_ASSERT_NOW(a_no_overwrite, req_fire, !r_out_valid || i_pix_ready)

endmodule

>>> dv/line_pixel_checker.sv
// scoreboard that predicts and checks the pixels of the styled line generator
`timescale 1ns / 1ps

module line_pixel_checker
    import slpg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  t_line_req             i_req,
    input  logic                  i_pix_valid,
    input  logic                  i_pix_ready,
    input  t_pixel                i_pix,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    // register copies
    logic [PATTERN_LEN-1:0] dash;
    logic [COLOR_W-1:0]     pen;
    logic [DIM_W-1:0]       scr_w;
    logic [DIM_W-1:0]       scr_h;

    // line walk state
    logic                         line_on;
    logic signed [COORD_BITS-1:0] cur_x, cur_y, end_x, end_y;
    logic [COORD_BITS-1:0]        span_x, span_y;
    logic                         back_x, back_y;
    logic signed [COORD_BITS+1:0] err_acc;
    logic [PAT_IDX_W-1:0]         dash_pos;

    t_pixel pixels_due[$];
    int     fail_total;

    task automatic compare_field(input string name, input logic signed [15:0] want,
                                 input logic signed [15:0] got);
        if (got !== want) begin
            fail_total++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic load_line(input t_line_req r);
        int x1, y1, x2, y2;
        x1 = int'($signed(r.x_start));
        y1 = int'($signed(r.y_start));
        x2 = int'($signed(r.x_end));
        y2 = int'($signed(r.y_end));
        cur_x    = r.x_start;
        cur_y    = r.y_start;
        end_x    = r.x_end;
        end_y    = r.y_end;
        span_x   = COORD_BITS'(x1 > x2 ? x1 - x2 : x2 - x1);
        span_y   = COORD_BITS'(y1 > y2 ? y1 - y2 : y2 - y1);
        back_x   = !(x1 < x2);
        back_y   = !(y1 < y2);
        err_acc  = (COORD_BITS + 2)'(int'(span_x) - int'(span_y));
        dash_pos = '0;
        line_on  = 1'b1;
    endtask

    // current pixel, then one bresenham iteration
    function automatic t_pixel walk_one_pixel();
        t_pixel px;
        int     x, y, dx, dy, err, e2;
        logic   in_screen, fin;
        x  = int'(cur_x);
        y  = int'(cur_y);
        dx = int'(span_x);
        dy = int'(span_y);
        in_screen = (x >= 0) && (x < int'(scr_w)) && (y >= 0) && (y < int'(scr_h));
        fin = (cur_x == end_x) && (cur_y == end_y);
        px.pixel_x = cur_x;
        px.pixel_y = cur_y;
        px.draw    = dash[dash_pos] && in_screen;
        px.color   = pen;
        px.last    = fin;
        if (fin) begin
            line_on = 1'b0;
        end else begin
            err = int'(err_acc);
            e2  = 2 * err;
            if (e2 > -dy) begin
                err -= dy;
                x += back_x ? -1 : 1;
            end
            if (e2 < dx) begin
                err += dx;
                y += back_y ? -1 : 1;
            end
            cur_x    = COORD_BITS'(x);
            cur_y    = COORD_BITS'(y);
            err_acc  = (COORD_BITS + 2)'(err);
            dash_pos = dash_pos + 1'b1;
        end
        return px;
    endfunction

    always @(posedge i_clk) begin
        t_pixel want;
        t_pixel got;
        if (!i_rst_n) begin
            dash       = DASH_RESET;
            pen        = COLOR_RESET;
            scr_w      = WIDTH_RESET;
            scr_h      = HEIGHT_RESET;
            line_on    = 1'b0;
            cur_x      = '0;
            cur_y      = '0;
            end_x      = '0;
            end_y      = '0;
            span_x     = '0;
            span_y     = '0;
            back_x     = 1'b0;
            back_y     = 1'b0;
            err_acc    = '0;
            dash_pos   = '0;
            fail_total = 0;
            pixels_due.delete();
        end else begin
            // pixels leaving now belong to earlier requests
            if (i_pix_valid && i_pix_ready) begin
                got = i_pix;
                if (pixels_due.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected pixel, expected none, got x=%0d y=%0d",
                             $time, got.pixel_x, got.pixel_y);
                end else begin
                    want = pixels_due.pop_front();
                    compare_field("pixel_x", want.pixel_x, got.pixel_x);
                    compare_field("pixel_y", want.pixel_y, got.pixel_y);
                    compare_field("draw", want.draw, got.draw);
                    compare_field("color", want.color, got.color);
                    compare_field("last", want.last, got.last);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DASH_PATTERN:  dash  = i_cfg_data[PATTERN_LEN-1:0];
                    CFG_PEN_COLOR:     pen   = i_cfg_data[COLOR_W-1:0];
                    CFG_SCREEN_WIDTH:  scr_w = i_cfg_data[DIM_W-1:0];
                    CFG_SCREEN_HEIGHT: scr_h = i_cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready) begin
                if (i_req.operation == OP_START) begin
                    load_line(i_req);
                end else if (line_on) begin
                    pixels_due.push_back(walk_one_pixel());
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= pixels_due.size();
    end

endmodule

>>> dv/tb.sv
// stimulus and verdict for the styled line pixel generator
`timescale 1ns / 1ps

module tb;
    import slpg_pkg::*;

    localparam int    ITEM_TARGET   = 850;     // counted requests in the random part
    localparam int    PHASE_ITEMS   = 110;     // counted requests per register setting
    localparam int    MAX_WAIT      = 11;      // longest idle or stall per request
    localparam int    SETTLE_CYCLES = 4;       // extra wait after pending drains, as margin
    localparam longint CYCLE_LIMIT  = 500000;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_ready;
    t_line_req             req;
    logic                  pix_valid;
    logic                  pix_ready;
    t_pixel                pix;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;

    // quiet stretches on each side, toggled now and then
    bit req_calm = 1'b0;
    bit pix_calm = 1'b0;

    // screen size as last programmed, used to aim lines at the edges
    int scr_w_now = int'(WIDTH_RESET);
    int scr_h_now = int'(HEIGHT_RESET);

    longint cycles = 0;

    styled_line_pixel_generator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_pix_valid (pix_valid),
        .i_pix_ready (pix_ready),
        .o_pix       (pix),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    line_pixel_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req        (req),
        .i_pix_valid  (pix_valid),
        .i_pix_ready  (pix_ready),
        .i_pix        (pix),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop in case the pixel stream hangs
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // cycles to wait before the next request or pixel; no wait in a quiet stretch
    function automatic int pick_wait(inout bit calm);
        if ($urandom_range(0, 24) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // step request; the coordinate fields are ignored by the block, so fill them anyway
    function automatic t_line_req step_req();
        t_line_req   r;
        logic [63:0] noise;
        noise       = {$urandom, $urandom};
        r           = noise[$bits(t_line_req)-1:0];
        r.operation = OP_STEP;
        return r;
    endfunction

    function automatic t_line_req start_req(input int x1, input int y1,
                                            input int x2, input int y2);
        t_line_req r;
        r.operation = OP_START;
        r.x_start   = COORD_BITS'(x1);
        r.y_start   = COORD_BITS'(y1);
        r.x_end     = COORD_BITS'(x2);
        r.y_end     = COORD_BITS'(y2);
        return r;
    endfunction

    // point within reach of a centre, clamped so the coordinate never wraps
    function automatic logic [COORD_BITS-1:0] jitter_coord(input int centre,
                                                           input int reach);
        int v;
        v = centre - reach + int'($urandom_range(0, 2 * reach));
        if (v > 2047)
            v = 2047;
        if (v < -2048)
            v = -2048;
        return COORD_BITS'(v);
    endfunction

    // short line, starting anywhere, near the origin or near the far screen corner
    function automatic t_line_req random_line();
        t_line_req r;
        int        reach;
        r           = step_req();
        r.operation = OP_START;
        reach       = ($urandom_range(0, 7) == 0) ? 40 : 12;
        case ($urandom_range(0, 2))
            0: begin
                r.x_start = COORD_BITS'($urandom);
                r.y_start = COORD_BITS'($urandom);
            end
            1: begin
                r.x_start = jitter_coord(0, 8);
                r.y_start = jitter_coord(0, 8);
            end
            default: begin
                r.x_start = jitter_coord(scr_w_now, 8);
                r.y_start = jitter_coord(scr_h_now, 8);
            end
        endcase
        r.x_end = jitter_coord(int'($signed(r.x_start)), reach);
        r.y_end = jitter_coord(int'($signed(r.y_start)), reach);
        return r;
    endfunction

    // bresenham gives one pixel per step of the longer axis
    function automatic int pixel_count(input t_line_req r);
        int ax, ay;
        ax = int'($signed(r.x_end)) - int'($signed(r.x_start));
        ay = int'($signed(r.y_end)) - int'($signed(r.y_start));
        if (ax < 0)
            ax = -ax;
        if (ay < 0)
            ay = -ay;
        return (ax > ay ? ax : ay) + 1;
    endfunction

    // one request, entered at a falling edge and left at the falling edge after
    // acceptance; valid stays high so a back-to-back request follows directly
    task automatic send_req(input t_line_req r);
        int gap;
        gap = pick_wait(req_calm);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_steps(input int n);
        repeat (n) send_req(step_req());
    endtask

    // drop valid and let every predicted pixel drain before touching registers
    task automatic settle();
        req_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // all four registers back to back, then valid low again
    task automatic write_regs(input logic [CFG_DATA_W-1:0] pat,
                              input logic [CFG_DATA_W-1:0] col,
                              input logic [CFG_DATA_W-1:0] wid,
                              input logic [CFG_DATA_W-1:0] hgt);
        logic [CFG_IDX_W-1:0]  regs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        regs = '{CFG_DASH_PATTERN, CFG_PEN_COLOR, CFG_SCREEN_WIDTH, CFG_SCREEN_HEIGHT};
        vals = '{pat, col, wid, hgt};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        scr_w_now = int'(wid[DIM_W-1:0]);
        scr_h_now = int'(hgt[DIM_W-1:0]);
    endtask

    // pixel side: a random stall before each pixel, then ready until one is taken
    initial begin
        int stall;
        pix_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            stall = pick_wait(pix_calm);
            if (stall > 0) begin
                pix_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pix_ready <= 1'b1;
            @(posedge clk);
            while (!pix_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    // request side and verdict
    initial begin
        t_line_req line;
        int        counted;
        int        phase;
        int        phase_end;
        int        kind;
        int        n;

        req_valid = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_DASH_PATTERN;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part, reset register values: solid pattern on 640 x 480
        send_steps(1);                            // step with no line: swallowed
        send_req(start_req(0, 0, 3, 1));          // shallow line from the origin
        send_steps(4);
        send_steps(1);                            // step after the last pixel
        send_req(start_req(7, 7, 7, 7));          // equal endpoints: one last pixel
        send_steps(1);
        send_req(start_req(-2048, 2047, -2046, 2045));  // most negative / positive
        send_steps(3);
        send_req(start_req(2047, -2048, -2048, 2047));  // long diagonal, abandoned
        send_steps(2);
        send_req(start_req(639, 479, 640, 480));  // crosses the bottom-right clip
        send_steps(2);
        send_req(start_req(10, 0, 7, 3));         // x walks negative, y positive
        send_steps(4);

        // random part: one register setting per phase, extremes first
        counted = 0;
        phase   = 0;
        while (counted < ITEM_TARGET) begin
            settle();
            case (phase)
                0: write_regs(16'hFFFF, 16'h0000, 16'd2047, 16'd2047);
                1: write_regs(16'h0000, 16'hFFFF, 16'd1, 16'd1);
                2: write_regs(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                              16'hF800, 16'h0000);   // empty screen, upper bits dropped
                3: write_regs(16'h8001, CFG_DATA_W'($urandom), 16'd2047, 16'd1);
                default: write_regs(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                    {5'($urandom), DIM_W'($urandom_range(1, 2047))},
                                    {5'($urandom), DIM_W'($urandom_range(1, 2047))});
            endcase
            phase_end = counted + PHASE_ITEMS;
            while (counted < phase_end && counted < ITEM_TARGET) begin
                kind = $urandom_range(0, 9);
                if (kind <= 6 || kind == 9) begin
                    // whole line walked to its last pixel
                    line = random_line();
                    n    = pixel_count(line);
                    send_req(line);
                    send_steps(n);
                    counted += n + 1;
                    if (kind == 9)
                        send_steps($urandom_range(1, 3));   // idle steps, not counted
                end else if (kind == 7) begin
                    // far endpoints, left unfinished and replaced by a later start
                    line = start_req($urandom, $urandom, $urandom, $urandom);
                    n    = $urandom_range(0, 20);
                    send_req(line);
                    send_steps(n);
                    counted += n + 1;
                end else begin
                    // odd request with any operation and any coordinates
                    line           = step_req();
                    line.operation = $urandom_range(0, 1) ? OP_STEP : OP_START;
                    send_req(line);
                    if (line.operation == OP_START)
                        counted++;
                end
            end
            phase++;
        end

        settle();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
